// File: src/mdcg_pkg.sv
// Package with the constants and state type of the magic divisor constant generator.
`default_nettype none
package mdcg_pkg;

   localparam int unsigned WORD_BITS = 32;
   localparam int unsigned SHIFT_BITS = 5;

   localparam logic [WORD_BITS-1:0] DIVISOR_MIN_VALID = 32'h0000_0002;
   localparam logic [WORD_BITS-1:0] DIVISOR_MAX_VALID = 32'h7FFF_FFFF;

   // The scaled divisor is normalized into the range (2^30, 2^31].
   localparam logic [WORD_BITS-1:0] NORM_COARSE_LIMIT = 32'h0400_0000;
   localparam logic [WORD_BITS-1:0] NORM_FINE_LIMIT = 32'h4000_0000;
   localparam logic [SHIFT_BITS-1:0] NORM_COARSE_STEP = 5'd4;
   localparam logic [SHIFT_BITS-1:0] NORM_FINE_STEP = 5'd1;

   // Upper bits of the scaled dividend 2^62 + D - 1, and the largest normalizing shift.
   localparam logic [WORD_BITS-2:0] DIV_REM_INIT = 31'h4000_0000;
   localparam logic [SHIFT_BITS-1:0] SHIFT_MAX = 5'd30;
   localparam logic [SHIFT_BITS-1:0] DIV_LAST_STEP = 5'd31;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_NORM   = 4'b0010,
      ST_DIV    = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

endpackage
`default_nettype wire

// File: src/magic_divisor_constant_generator.sv
// Top level of the magic divisor constant generator with its normalizer and serial divider.
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_stall  req_divisor[31:0]
//   rsp       out         rsp_valid/rsp_stall  rsp_multiplier[31:0], rsp_shift_amount[4:0]
//
// A valid divisor is accepted, normalized (four or one bit positions per cycle), run
// through the restoring divider (one quotient bit per cycle) and loaded into the output
// register once that is free. An invalid divisor skips both and gives an all-zero result.
// Reset is synchronous and active high; it empties the block and the output register.
// The next divisor is accepted while a result still waits in the output register.
`default_nettype none
module magic_divisor_constant_generator (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [mdcg_pkg::WORD_BITS-1:0]       req_divisor,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [mdcg_pkg::WORD_BITS-1:0]            rsp_multiplier,
   output logic [mdcg_pkg::SHIFT_BITS-1:0]           rsp_shift_amount
);

   mdcg_pkg::state_type state_ff, state_in;
   logic [mdcg_pkg::WORD_BITS-1:0]  den_ff, den_in;
   logic [mdcg_pkg::WORD_BITS-2:0]  rem_ff, rem_in;
   logic [mdcg_pkg::WORD_BITS-1:0]  lo_ff, lo_in;
   logic [mdcg_pkg::SHIFT_BITS-1:0] norm_ff, norm_in;
   logic [mdcg_pkg::SHIFT_BITS-1:0] step_ff, step_in;
   logic                            zero_ff, zero_in;
   logic                            out_valid_ff, out_valid_in;
   logic [mdcg_pkg::WORD_BITS-1:0]  out_mul_ff, out_mul_in;
   logic [mdcg_pkg::SHIFT_BITS-1:0] out_shift_ff, out_shift_in;

   logic                            req_transfer;
   logic                            out_free;
   logic [mdcg_pkg::WORD_BITS-1:0]  trial;
   logic [mdcg_pkg::WORD_BITS:0]    diff;
   logic                            ge;

   assign req_stall = (state_ff != mdcg_pkg::ST_IDLE);
   assign req_transfer = req_valid && !req_stall;
   assign out_free = !out_valid_ff || !rsp_stall;

   assign trial = {rem_ff, lo_ff[mdcg_pkg::WORD_BITS-1]};
   assign diff = {1'b0, trial} - {1'b0, den_ff};
   assign ge = !diff[mdcg_pkg::WORD_BITS];

   always_comb begin
      state_in = state_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      lo_in = lo_ff;
      norm_in = norm_ff;
      step_in = step_ff;
      zero_in = zero_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_mul_in = out_mul_ff;
      out_shift_in = out_shift_ff;
      case (state_ff)
         mdcg_pkg::ST_IDLE: begin
            if (req_transfer) begin
               den_in = req_divisor;
               norm_in = '0;
               lo_in = '0;
               if (req_divisor >= mdcg_pkg::DIVISOR_MIN_VALID
                   && req_divisor <= mdcg_pkg::DIVISOR_MAX_VALID) begin
                  zero_in = 1'b0;
                  state_in = mdcg_pkg::ST_NORM;
               end else begin
                  zero_in = 1'b1;
                  state_in = mdcg_pkg::ST_FINISH;
               end
            end
         end
         mdcg_pkg::ST_NORM: begin
            if (den_ff <= mdcg_pkg::NORM_COARSE_LIMIT) begin
               den_in = {den_ff[mdcg_pkg::WORD_BITS-5:0], 4'b0000};
               norm_in = norm_ff + mdcg_pkg::NORM_COARSE_STEP;
            end else if (den_ff <= mdcg_pkg::NORM_FINE_LIMIT) begin
               den_in = {den_ff[mdcg_pkg::WORD_BITS-2:0], 1'b0};
               norm_in = norm_ff + mdcg_pkg::NORM_FINE_STEP;
            end else begin
               rem_in = mdcg_pkg::DIV_REM_INIT;
               lo_in = den_ff - 32'd1;
               step_in = mdcg_pkg::DIV_LAST_STEP;
               state_in = mdcg_pkg::ST_DIV;
            end
         end
         mdcg_pkg::ST_DIV: begin
            rem_in = ge ? diff[mdcg_pkg::WORD_BITS-2:0] : trial[mdcg_pkg::WORD_BITS-2:0];
            lo_in = {lo_ff[mdcg_pkg::WORD_BITS-2:0], ge};
            step_in = step_ff - 5'd1;
            if (step_ff == '0) begin
               state_in = mdcg_pkg::ST_FINISH;
            end
         end
         mdcg_pkg::ST_FINISH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_mul_in = lo_ff;
               out_shift_in = zero_ff ? '0 : (mdcg_pkg::SHIFT_MAX - norm_ff);
               state_in = mdcg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mdcg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mdcg_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
      den_ff <= den_in;
      rem_ff <= rem_in;
      lo_ff <= lo_in;
      norm_ff <= norm_in;
      step_ff <= step_in;
      zero_ff <= zero_in;
      out_mul_ff <= out_mul_in;
      out_shift_ff <= out_shift_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_multiplier = out_mul_ff;
   assign rsp_shift_amount = out_shift_ff;

   // The divider always works on a normalized divisor above 2^30.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == mdcg_pkg::ST_DIV |-> den_ff > mdcg_pkg::NORM_FINE_LIMIT)
      else $error("divisor not normalized during division");

   // The partial remainder stays below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == mdcg_pkg::ST_DIV |-> {1'b0, rem_ff} < den_ff)
      else $error("partial remainder not below divisor");

   // A result is either all zero or carries a multiplier of at least 2^31.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_multiplier[31] || (rsp_multiplier == '0 && rsp_shift_amount == '0))
      else $error("multiplier out of range");

   // A result is loaded only when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == mdcg_pkg::ST_FINISH && out_valid_ff && rsp_stall
      |=> state_ff == mdcg_pkg::ST_FINISH)
      else $error("result left the divider while the output was blocked");

endmodule
`default_nettype wire
